[hdl/pal_pkg.sv]
// ============================================================================
// pal_pkg: shared types and constants for the positional array list
// Request and result item structs, op and status codes, storage sizing.
// ============================================================================
`default_nettype none

package pal_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_APPEND   = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_LOCATE   = 3'd3;
    localparam logic [2:0] OP_RETRIEVE = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BOUNDS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]       op;
        logic [POS_W-1:0] position;
        logic [63:0]      value;
    } pal_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  found_position;
        logic [63:0] read_value;
        logic [6:0]  entry_count;
    } pal_rsp_t;

endpackage

`default_nettype wire

[hdl/positional_array_list.sv]
// ============================================================================
// positional_array_list: ordered list of 64-bit words with positional ops
// Insert, append, delete, locate, retrieve and clear over one RAM port pair.
// ============================================================================
// An item is taken when start is high and busy is low; its result appears
// on result for one cycle with done high and cannot be held off. Items are
// handled one at a time: busy stays high from accept until the result is
// shown. Append, clear, unused ops and every rejected request finish in
// DISPATCH; retrieve goes through READ and RETR; insert or delete first
// moves the entries behind the position; locate scans until a match. The
// single read and single write port of the entry RAM make moves and scans
// go one entry per cycle.
`default_nettype none

module positional_array_list
    import pal_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire pal_req_t request,
    output logic          busy,
    output logic          done,
    output pal_rsp_t      result
);

    typedef enum logic [2:0] {
        IDLE,
        DISPATCH,
        MOVE,
        FINAL,
        SCAN,
        READ,
        RETR
    } state_t;

    state_t           state_reg;
    logic [2:0]       op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [63:0]      val_reg;
    logic [CNT_W-1:0] count_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] wr_idx_reg;
    logic [ADDR_W-1:0] last_reg;
    logic             rd_more_reg;
    logic             wr_pend_reg;
    logic             done_reg;
    pal_rsp_t         result_reg;

    logic [63:0]      mem [CAPACITY];
    logic [63:0]      rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [63:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [ADDR_W-1:0] pos_slot;
    logic [ADDR_W-1:0] cnt_last;
    logic              is_full;
    logic              pos_bad;   // outside 1..count
    logic              ins_bad;   // outside 1..count+1

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_slot = ADDR_W'(pos_ext - CMP_W'(1));
    assign cnt_last = ADDR_W'(cnt_ext - CMP_W'(1));
    assign is_full  = (cnt_ext == CMP_W'(CAPACITY));
    assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
    assign ins_bad  = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg;
        mem_wdata = rd_data_reg;
        mem_raddr = rd_idx_reg;
        unique case (state_reg)
            DISPATCH:
            begin
                if (op_reg == OP_APPEND && !is_full)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(count_reg);
                    mem_wdata = val_reg;
                end
            end
            MOVE:
            begin
                mem_we = wr_pend_reg;
            end
            FINAL:
            begin
                if (op_reg == OP_INSERT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_slot;
                    mem_wdata = val_reg;
                end
            end
            READ:
            begin
                mem_raddr = pos_slot;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            rd_more_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            op_reg      <= '0;
            pos_reg     <= '0;
            val_reg     <= '0;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            last_reg    <= '0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= request.op;
                        pos_reg   <= request.position;
                        val_reg   <= request.value;
                        state_reg <= DISPATCH;
                    end
                end
                DISPATCH:
                begin
                    rd_more_reg <= 1'b1;
                    wr_pend_reg <= 1'b0;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (is_full || ins_bad)
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: is_full ? ST_FULL : ST_BOUNDS,
                                                found_position: 7'd0, read_value: 64'd0,
                                                entry_count: 7'(count_reg)};
                                state_reg  <= IDLE;
                            end
                            else if (pos_ext <= cnt_ext)
                            begin
                                // walk down from the last entry, each one up a slot
                                rd_idx_reg <= cnt_last;
                                last_reg   <= pos_slot;
                                state_reg  <= MOVE;
                            end
                            else
                            begin
                                state_reg <= FINAL;
                            end
                        end
                        OP_APPEND:
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: is_full ? ST_FULL : ST_OK,
                                            found_position: 7'd0, read_value: 64'd0,
                                            entry_count: is_full ? 7'(count_reg)
                                                : 7'(cnt_ext + CMP_W'(1))};
                            if (!is_full)
                            begin
                                count_reg <= CNT_W'(cnt_ext + CMP_W'(1));
                            end
                            state_reg  <= IDLE;
                        end
                        OP_DELETE:
                        begin
                            if (pos_bad)
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: ST_BOUNDS,
                                                found_position: 7'd0, read_value: 64'd0,
                                                entry_count: 7'(count_reg)};
                                state_reg  <= IDLE;
                            end
                            else if (pos_ext < cnt_ext)
                            begin
                                // walk up from the entry after the gap, each one down a slot
                                rd_idx_reg <= ADDR_W'(pos_ext);
                                last_reg   <= cnt_last;
                                state_reg  <= MOVE;
                            end
                            else
                            begin
                                state_reg <= FINAL;
                            end
                        end
                        OP_LOCATE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: ST_NOTFOUND,
                                                found_position: 7'd0, read_value: 64'd0,
                                                entry_count: 7'd0};
                                state_reg  <= IDLE;
                            end
                            else
                            begin
                                rd_idx_reg <= '0;
                                last_reg   <= cnt_last;
                                state_reg  <= SCAN;
                            end
                        end
                        OP_RETRIEVE:
                        begin
                            if (pos_bad)
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: ST_BOUNDS,
                                                found_position: 7'd0, read_value: 64'd0,
                                                entry_count: 7'(count_reg)};
                                state_reg  <= IDLE;
                            end
                            else
                            begin
                                state_reg <= READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_reg  <= '0;
                            done_reg   <= 1'b1;
                            result_reg <= '{status: ST_OK, found_position: 7'd0,
                                            read_value: 64'd0, entry_count: 7'd0};
                            state_reg  <= IDLE;
                        end
                        default:
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: ST_OK, found_position: 7'd0,
                                            read_value: 64'd0,
                                            entry_count: 7'(count_reg)};
                            state_reg  <= IDLE;
                        end
                    endcase
                end
                MOVE:
                begin
                    // read one slot ahead; its data lands in the next cycle's write
                    if (rd_more_reg)
                    begin
                        wr_pend_reg <= 1'b1;
                        rd_more_reg <= (rd_idx_reg != last_reg);
                        if (op_reg == OP_INSERT)
                        begin
                            wr_idx_reg <= rd_idx_reg + ADDR_W'(1);
                            rd_idx_reg <= rd_idx_reg - ADDR_W'(1);
                        end
                        else
                        begin
                            wr_idx_reg <= rd_idx_reg - ADDR_W'(1);
                            rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
                        end
                    end
                    else
                    begin
                        wr_pend_reg <= 1'b0;
                        state_reg   <= FINAL;
                    end
                end
                FINAL:
                begin
                    done_reg <= 1'b1;
                    if (op_reg == OP_INSERT)
                    begin
                        count_reg  <= CNT_W'(cnt_ext + CMP_W'(1));
                        result_reg <= '{status: ST_OK, found_position: 7'd0,
                                        read_value: 64'd0,
                                        entry_count: 7'(cnt_ext + CMP_W'(1))};
                    end
                    else
                    begin
                        count_reg  <= CNT_W'(cnt_ext - CMP_W'(1));
                        result_reg <= '{status: ST_OK, found_position: 7'd0,
                                        read_value: 64'd0,
                                        entry_count: 7'(cnt_ext - CMP_W'(1))};
                    end
                    state_reg <= IDLE;
                end
                SCAN:
                begin
                    // wr_idx/wr_pend track the slot whose data is being compared
                    if (wr_pend_reg && rd_data_reg == val_reg)
                    begin
                        done_reg    <= 1'b1;
                        wr_pend_reg <= 1'b0;
                        result_reg  <= '{status: ST_OK,
                                         found_position: 7'(CMP_W'(wr_idx_reg) + CMP_W'(1)),
                                         read_value: 64'd0,
                                         entry_count: 7'(count_reg)};
                        state_reg   <= IDLE;
                    end
                    else if (rd_more_reg)
                    begin
                        wr_pend_reg <= 1'b1;
                        wr_idx_reg  <= rd_idx_reg;
                        rd_more_reg <= (rd_idx_reg != last_reg);
                        rd_idx_reg  <= rd_idx_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        done_reg    <= 1'b1;
                        wr_pend_reg <= 1'b0;
                        result_reg  <= '{status: ST_NOTFOUND,
                                         found_position: 7'(count_reg),
                                         read_value: 64'd0,
                                         entry_count: 7'(count_reg)};
                        state_reg   <= IDLE;
                    end
                end
                READ:
                begin
                    state_reg <= RETR;
                end
                RETR:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= '{status: ST_OK, found_position: 7'd0,
                                    read_value: rd_data_reg,
                                    entry_count: 7'(count_reg)};
                    state_reg  <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // count never exceeds the list capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    // writes stay inside the occupied region plus the append slot
    a_write_region: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CMP_W'(mem_waddr) <= CMP_W'(count_reg)))
        else $error("RAM write beyond list end");

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == IDLE))
        else $error("result strobe while busy");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start");

    // count moves by one or drops to zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == CNT_W'($past(count_reg) + CNT_W'(1)) ||
             count_reg == CNT_W'($past(count_reg) - CNT_W'(1)) ||
             count_reg == '0))
        else $error("entry count jumped");

endmodule

`default_nettype wire
